// ===== rtl/rc4x_pkg.sv =====
// Shared types and constants for the RC4 masked stream cipher.
// No dependencies; used by the S-box store, the top level and the checker.
package rc4x_pkg;

    localparam int SBOX_DEPTH = 256;
    localparam int KEY_MAX    = 256;
    localparam int KCNT_W     = 9;

    typedef logic [7:0]        t_byte;
    typedef logic [KCNT_W-1:0] t_kcnt;

    localparam t_byte MASK_RESET = 8'h36;
    localparam t_kcnt KEY_FULL   = t_kcnt'(KEY_MAX);

    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    typedef struct packed {
        logic  en;
        t_byte addr;
        t_byte data;
    } t_sbox_wr;

endpackage

// ===== rtl/rc4x_sbox.sv =====
// S-box store: 256 x 8 memory, one registered read port, one write port.
// Per-entry valid bits make unwritten entries read as their own index.
// Depends on rc4x_pkg.
module rc4x_sbox (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_clear,
    input  rc4x_pkg::t_byte    i_rd_addr,
    input  rc4x_pkg::t_sbox_wr i_wr,
    output rc4x_pkg::t_byte    o_rd_data
);

    rc4x_pkg::t_byte                 r_mem [rc4x_pkg::SBOX_DEPTH];
    logic [rc4x_pkg::SBOX_DEPTH-1:0] r_vld;
    rc4x_pkg::t_byte                 r_rd_data;
    rc4x_pkg::t_byte                 r_rd_addr;
    logic                            r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
        r_rd_addr <= i_rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[i_rd_addr];
            if (i_clear) begin
                r_vld <= '0;
            end else if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : r_rd_addr;

endmodule

// ===== rtl/rc4_stream_cipher_xor_mask.sv =====
// RC4 stream cipher with a constant output mask: top level.
// Depends on rc4x_pkg and rc4x_sbox.
//
// Input channel (i_in_valid / o_in_stall) carries i_command, i_byte_value and
// i_last_key; a transfer happens when valid is high and stall is low.
// A key byte (command 0) is stored while fewer than 256 are held and gives no
// result; the block is ready again on the next cycle. A key byte with last_key
// set starts the key schedule: 256 steps, each through the states RDP, RDJ, WRP
// and WRJ, during which o_in_stall is high.
// A data byte (command 1) runs one generator step through the S-box memory
// in states RDP, RDJ, WRP and WRJ (read S[i], read S[j], write S[i], write S[j]
// and capture the keystream byte); the result is then registered on
// o_out_valid, and no new item is taken until the block returns to idle after
// that capture.
// Output channel (o_out_valid / i_out_stall) is a registered stage; while the
// receiver stalls a full output register, the block holds the last phase of
// the next data byte until the register frees.
// Configuration channel (i_cfg_valid / o_cfg_ready) writes the output mask;
// o_cfg_ready is always high.
// Reset (i_rst_n low, synchronous) sets the S-box to the identity at once,
// clears indices and key count and loads mask 0x36.
module rc4_stream_cipher_xor_mask (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_command,
    input  logic [7:0] i_byte_value,
    input  logic       i_last_key,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_cipher_byte,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RDP  = 3'd1;
    localparam logic [2:0] ST_RDJ  = 3'd2;
    localparam logic [2:0] ST_WRP  = 3'd3;
    localparam logic [2:0] ST_WRJ  = 3'd4;

    logic [2:0]         r_state, n_state;
    logic               r_sched, n_sched;
    rc4x_pkg::t_byte    r_i, n_i;
    rc4x_pkg::t_byte    r_j, n_j;
    rc4x_pkg::t_byte    r_p, n_p;
    rc4x_pkg::t_byte    r_sp, n_sp;
    rc4x_pkg::t_byte    r_sj, n_sj;
    rc4x_pkg::t_byte    r_t, n_t;
    rc4x_pkg::t_byte    r_kidx, n_kidx;
    rc4x_pkg::t_kcnt    r_key_count, n_key_count;
    rc4x_pkg::t_byte    r_mask;
    rc4x_pkg::t_byte    r_data, n_data;
    logic               r_out_valid, n_out_valid;
    rc4x_pkg::t_byte    r_out, n_out;

    rc4x_pkg::t_byte    r_key_mem [rc4x_pkg::KEY_MAX];
    rc4x_pkg::t_byte    r_key_rd;

    logic               in_xfer;
    logic               out_free;
    logic               key_wr;
    logic               sbox_clear;
    rc4x_pkg::t_byte    sbox_rd_addr;
    rc4x_pkg::t_byte    sbox_rd_data;
    rc4x_pkg::t_sbox_wr sbox_wr;
    rc4x_pkg::t_byte    key_add;
    rc4x_pkg::t_byte    ks;

    rc4x_sbox u_sbox (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (sbox_clear),
        .i_rd_addr (sbox_rd_addr),
        .i_wr      (sbox_wr),
        .o_rd_data (sbox_rd_data)
    );

    assign o_in_stall    = (r_state != ST_IDLE);
    assign in_xfer       = i_in_valid && !o_in_stall;
    assign out_free      = !r_out_valid || !i_out_stall;
    assign o_out_valid   = r_out_valid;
    assign o_cipher_byte = r_out;
    assign o_cfg_ready   = 1'b1;

    assign key_wr = in_xfer && (i_command == rc4x_pkg::CMD_KEY)
                    && (r_key_count != rc4x_pkg::KEY_FULL);

    always_ff @(posedge i_clk) begin
        if (key_wr) begin
            r_key_mem[r_key_count[7:0]] <= i_byte_value;
        end
        r_key_rd <= r_key_mem[r_kidx];
    end

    assign key_add = r_sched ? r_key_rd : 8'd0;
    assign ks = (r_t == r_j) ? r_sp :
                (r_t == r_p) ? r_sj : sbox_rd_data;

    always_comb begin
        n_state     = r_state;
        n_sched     = r_sched;
        n_i         = r_i;
        n_j         = r_j;
        n_p         = r_p;
        n_sp        = r_sp;
        n_sj        = r_sj;
        n_t         = r_t;
        n_kidx      = r_kidx;
        n_key_count = r_key_count;
        n_data      = r_data;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        sbox_clear  = 1'b0;
        sbox_rd_addr = r_p;
        sbox_wr     = '0;

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (i_command == rc4x_pkg::CMD_KEY) begin
                        if (key_wr) begin
                            n_key_count = r_key_count + 9'd1;
                        end
                        if (i_last_key) begin
                            sbox_clear = 1'b1;
                            n_sched    = 1'b1;
                            n_p        = 8'd0;
                            n_j        = 8'd0;
                            n_kidx     = 8'd0;
                            n_state    = ST_RDP;
                        end
                    end else begin
                        n_sched = 1'b0;
                        n_i     = r_i + 8'd1;
                        n_p     = r_i + 8'd1;
                        n_data  = i_byte_value;
                        n_state = ST_RDP;
                    end
                end
            end
            ST_RDP: begin
                sbox_rd_addr = r_p;
                n_state      = ST_RDJ;
            end
            ST_RDJ: begin
                n_sp         = sbox_rd_data;
                n_j          = r_j + sbox_rd_data + key_add;
                sbox_rd_addr = r_j + sbox_rd_data + key_add;
                n_state      = ST_WRP;
            end
            ST_WRP: begin
                n_sj         = sbox_rd_data;
                n_t          = r_sp + sbox_rd_data;
                sbox_rd_addr = r_sp + sbox_rd_data;
                sbox_wr      = '{en: 1'b1, addr: r_p, data: sbox_rd_data};
                n_state      = ST_WRJ;
            end
            ST_WRJ: begin
                sbox_rd_addr = r_t;
                sbox_wr      = '{en: 1'b1, addr: r_j, data: r_sp};
                if (r_sched) begin
                    n_p = r_p + 8'd1;
                    if (({1'b0, r_kidx} + 9'd1) == r_key_count) begin
                        n_kidx = 8'd0;
                    end else begin
                        n_kidx = r_kidx + 8'd1;
                    end
                    if (r_p == 8'hFF) begin
                        n_i         = 8'd0;
                        n_j         = 8'd0;
                        n_key_count = '0;
                        n_sched     = 1'b0;
                        n_state     = ST_IDLE;
                    end else begin
                        n_state = ST_RDP;
                    end
                end else if (out_free) begin
                    n_out       = r_data ^ ks ^ r_mask;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sched     <= 1'b0;
            r_i         <= 8'd0;
            r_j         <= 8'd0;
            r_kidx      <= 8'd0;
            r_key_count <= '0;
            r_out_valid <= 1'b0;
            r_mask      <= rc4x_pkg::MASK_RESET;
        end else begin
            r_state     <= n_state;
            r_sched     <= n_sched;
            r_i         <= n_i;
            r_j         <= n_j;
            r_kidx      <= n_kidx;
            r_key_count <= n_key_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_mask <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p    <= n_p;
        r_sp   <= n_sp;
        r_sj   <= n_sj;
        r_t    <= n_t;
        r_data <= n_data;
        r_out  <= n_out;
    end

endmodule

// ===== rtl/rc4x_checker.sv =====
// Port-level checker for the RC4 masked stream cipher, bound to the top level.
// Depends on rc4x_pkg and rc4_stream_cipher_xor_mask.
module rc4x_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       i_command,
    input logic       i_last_key,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_cipher_byte
);

    logic in_xfer;
    assign in_xfer = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_cipher_byte))
        else $error("stalled result changed or dropped");

    a_key_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_command == rc4x_pkg::CMD_KEY) |=> !$rose(o_out_valid))
        else $error("key transfer produced a result");

    a_busy_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && ((i_command == rc4x_pkg::CMD_DATA) || i_last_key) |=> o_in_stall)
        else $error("block ready right after taking work");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without work in progress");

endmodule

bind rc4_stream_cipher_xor_mask rc4x_checker u_rc4x_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_command     (i_command),
    .i_last_key    (i_last_key),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_cipher_byte (o_cipher_byte)
);
